[src/mf2d_pkg.sv]
package mf2d_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int INDEX_W    = 6;
   localparam int CNT_W      = 7;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int PC_W       = 3;

   typedef struct packed {
      logic                       kind;
      logic [INDEX_W-1:0]         row;
      logic [INDEX_W-1:0]         col;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] result;
      logic                       ok;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] row_count;
      logic [CNT_W-1:0] col_count;
      logic [CNT_W-1:0] window_size;
   } cfg_type;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_ROW_COUNT   = 2'd0;
   localparam reg_index_type REG_COL_COUNT   = 2'd1;
   localparam reg_index_type REG_WINDOW_SIZE = 2'd2;

   localparam logic [CNT_W-1:0] ROW_COUNT_RESET   = 7'd64;
   localparam logic [CNT_W-1:0] COL_COUNT_RESET   = 7'd64;
   localparam logic [CNT_W-1:0] WINDOW_SIZE_RESET = 7'd3;

   typedef enum logic [1:0] {
      COND_STEP,
      COND_ALWAYS,
      COND_LOOP,
      COND_DISPATCH
   } cond_type;

   typedef enum logic [1:0] {
      SEL_WRITE,
      SEL_ZERO,
      SEL_RAW,
      SEL_MAX
   } rsp_sel_type;

   typedef enum logic [1:0] {
      CLASS_WRITE,
      CLASS_ZERO,
      CLASS_RAW,
      CLASS_SCAN
   } item_class_type;

   typedef logic [PC_W-1:0] pc_type;
   localparam pc_type PC_IDLE     = 3'd0;
   localparam pc_type PC_WRITE    = 3'd1;
   localparam pc_type PC_ZERO     = 3'd2;
   localparam pc_type PC_RAW_RD   = 3'd3;
   localparam pc_type PC_RAW_OUT  = 3'd4;
   localparam pc_type PC_SCAN     = 3'd5;
   localparam pc_type PC_SCAN_OUT = 3'd6;

   typedef struct packed {
      cond_type    cond;
      pc_type      target;
      logic        busy;
      logic        mem_we;
      logic        rd_centre;
      logic        rd_scan;
      logic        rsp_en;
      rsp_sel_type rsp_sel;
   } uword_type;

   typedef struct packed {
      item_class_type item_class;
      logic           scan_more;
   } dp_status_type;

   // control store: cond, target, busy, we, rd_centre, rd_scan, rsp_en, sel
   function automatic uword_type ucode_rom(input pc_type pc);
      uword_type w;
      unique case (pc)
         PC_IDLE:     w = '{COND_DISPATCH, PC_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEL_ZERO};
         PC_WRITE:    w = '{COND_ALWAYS,   PC_IDLE, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, SEL_WRITE};
         PC_ZERO:     w = '{COND_ALWAYS,   PC_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, SEL_ZERO};
         PC_RAW_RD:   w = '{COND_STEP,     PC_IDLE, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, SEL_RAW};
         PC_RAW_OUT:  w = '{COND_ALWAYS,   PC_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, SEL_RAW};
         PC_SCAN:     w = '{COND_LOOP,     PC_SCAN, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, SEL_MAX};
         PC_SCAN_OUT: w = '{COND_ALWAYS,   PC_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, SEL_MAX};
         default:     w = '{COND_ALWAYS,   PC_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, SEL_ZERO};
      endcase
      return w;
   endfunction

   function automatic pc_type dispatch_pc(input item_class_type c);
      pc_type p;
      unique case (c)
         CLASS_WRITE: p = PC_WRITE;
         CLASS_ZERO:  p = PC_ZERO;
         CLASS_RAW:   p = PC_RAW_RD;
         CLASS_SCAN:  p = PC_SCAN;
         default:     p = PC_IDLE;
      endcase
      return p;
   endfunction

endpackage

[src/max_filter_2d_core.sv]
// channel  | ports                                   | beat taken when
// ---------+-----------------------------------------+-----------------------------------
// request  | start, busy, req_data                   | start && !busy at a rising edge
// response | rsp_strobe, rsp_data                    | every cycle rsp_strobe is high
// csr      | psel penable pwrite paddr pwdata prdata | psel && penable && pwrite && pready
//
// A write or a query off the store runs PC_WRITE or PC_ZERO, a bad window PC_RAW_RD then
// PC_RAW_OUT, a filtered query PC_SCAN over the clipped window then PC_SCAN_OUT; a new beat
// is taken only in PC_IDLE. The sample memory has a single read port: one sample per cycle.
// The response shows in the cycle after the last sequencer step, when busy is already low.
// Reset is synchronous; the sample memory is not cleared. The receiver cannot stall.
module max_filter_2d_core #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  mf2d_pkg::req_type               req_data,
   output logic                            rsp_strobe,
   output mf2d_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mf2d_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mf2d_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mf2d_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import mf2d_pkg::*;

   cfg_type       cfg;
   uword_type     uword;
   dp_status_type status;
   logic          accept;

   assign busy   = uword.busy;
   assign accept = start && !uword.busy;

   mf2d_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mf2d_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .uword  (uword)
   );

   mf2d_datapath #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .cfg        (cfg),
      .uword      (uword),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[src/mf2d_csr.sv]
module mf2d_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mf2d_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [mf2d_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [mf2d_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output mf2d_pkg::cfg_type                 cfg
);
   import mf2d_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = paddr[CSR_ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_ROW_COUNT:   cfg_in.row_count   = pwdata[CNT_W-1:0];
            REG_COL_COUNT:   cfg_in.col_count   = pwdata[CNT_W-1:0];
            REG_WINDOW_SIZE: cfg_in.window_size = pwdata[CNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_ROW_COUNT:   prdata = CSR_DATA_W'(cfg_ff.row_count);
         REG_COL_COUNT:   prdata = CSR_DATA_W'(cfg_ff.col_count);
         REG_WINDOW_SIZE: prdata = CSR_DATA_W'(cfg_ff.window_size);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{ROW_COUNT_RESET, COL_COUNT_RESET, WINDOW_SIZE_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/mf2d_sequencer.sv]
module mf2d_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  mf2d_pkg::dp_status_type status,
   output mf2d_pkg::uword_type     uword
);
   import mf2d_pkg::*;

   pc_type pc_ff, pc_in;

   assign uword = ucode_rom(pc_ff);

   always_comb begin
      unique case (uword.cond)
         COND_STEP:     pc_in = pc_ff + 3'd1;
         COND_ALWAYS:   pc_in = uword.target;
         COND_LOOP:     pc_in = status.scan_more ? uword.target : pc_ff + 3'd1;
         COND_DISPATCH: pc_in = start ? dispatch_pc(status.item_class) : uword.target;
         default:       pc_in = PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[src/mf2d_datapath.sv]
module mf2d_datapath #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  mf2d_pkg::req_type       req_data,
   input  mf2d_pkg::cfg_type       cfg,
   input  mf2d_pkg::uword_type     uword,
   output mf2d_pkg::dp_status_type status,
   output logic                    rsp_strobe,
   output mf2d_pkg::rsp_type       rsp_data
);
   import mf2d_pkg::*;

   localparam int DEPTH    = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EXT_W    = (DATA_WIDTH > SAMPLE_W) ? DATA_WIDTH : SAMPLE_W;
   localparam int ROWS_CAP = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
   localparam int COLS_CAP = (MAX_COLS > 127) ? 127 : MAX_COLS;

   logic [DATA_WIDTH-1:0] pixel_store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] mem_q_ff;
   logic [DATA_WIDTH-1:0] best_ff;
   logic [DATA_WIDTH-1:0] run_max;
   logic [DATA_WIDTH-1:0] store_val;
   logic [EXT_W-1:0]      store_ext, raw_ext, max_ext;

   logic [INDEX_W-1:0]         row_ff, col_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       in_store_ff;
   logic [CNT_W-1:0]           r_ff, c_ff, c_lo_ff, r_hi_ff, c_hi_ff;
   logic                       scan_pend_ff;
   logic                       rsp_strobe_ff;
   rsp_type                    rsp_data_ff, rsp_in;

   logic [CNT_W-1:0] rows_eff, cols_eff, radius, row7, col7;
   logic [CNT_W-1:0] r_lo, c_lo, r_sum, c_sum, r_hi, c_hi;
   logic             in_store, win_ok;
   logic [ADDR_W-1:0] centre_addr, scan_addr, rd_addr;

   // clipped window bounds, worked out from the beat being accepted
   always_comb begin
      rows_eff = (cfg.row_count > CNT_W'(ROWS_CAP)) ? CNT_W'(ROWS_CAP) : cfg.row_count;
      cols_eff = (cfg.col_count > CNT_W'(COLS_CAP)) ? CNT_W'(COLS_CAP) : cfg.col_count;
      radius   = {1'b0, cfg.window_size[CNT_W-1:1]};
      row7     = {1'b0, req_data.row};
      col7     = {1'b0, req_data.col};
      r_lo     = (row7 >= radius) ? row7 - radius : '0;
      c_lo     = (col7 >= radius) ? col7 - radius : '0;
      r_sum    = row7 + radius;
      c_sum    = col7 + radius;
      r_hi     = (r_sum > rows_eff - 7'd1) ? rows_eff - 7'd1 : r_sum;
      c_hi     = (c_sum > cols_eff - 7'd1) ? cols_eff - 7'd1 : c_sum;
      in_store = (32'(req_data.row) < MAX_ROWS) && (32'(req_data.col) < MAX_COLS);
      win_ok   = cfg.window_size[0] && (cfg.window_size <= rows_eff) &&
                 (cfg.window_size <= cols_eff) && (row7 < rows_eff) && (col7 < cols_eff);
   end

   always_comb begin
      status.scan_more = !((r_ff == r_hi_ff) && (c_ff == c_hi_ff));
      priority if (!req_data.kind) begin
         status.item_class = CLASS_WRITE;
      end else if (!in_store) begin
         status.item_class = CLASS_ZERO;
      end else if (!win_ok) begin
         status.item_class = CLASS_RAW;
      end else begin
         status.item_class = CLASS_SCAN;
      end
   end

   assign centre_addr = ADDR_W'(32'(row_ff) * MAX_COLS + 32'(col_ff));
   assign scan_addr   = ADDR_W'(32'(r_ff) * MAX_COLS + 32'(c_ff));
   assign rd_addr     = uword.rd_centre ? centre_addr : scan_addr;

   assign store_ext = EXT_W'($unsigned(sample_ff));
   assign store_val = store_ext[DATA_WIDTH-1:0];

   assign run_max = ($signed(mem_q_ff) > $signed(best_ff)) ? mem_q_ff : best_ff;
   assign raw_ext = EXT_W'(mem_q_ff);
   assign max_ext = EXT_W'(run_max);

   always_comb begin
      unique case (uword.rsp_sel)
         SEL_WRITE: rsp_in = '{'0, 1'b1};
         SEL_ZERO:  rsp_in = '{'0, 1'b0};
         SEL_RAW:   rsp_in = '{raw_ext[SAMPLE_W-1:0], 1'b0};
         SEL_MAX:   rsp_in = '{max_ext[SAMPLE_W-1:0], 1'b1};
         default:   rsp_in = '{'0, 1'b0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (uword.mem_we && in_store_ff) begin
         pixel_store_ff[centre_addr] <= store_val;
      end
      if (uword.rd_centre || uword.rd_scan) begin
         mem_q_ff <= pixel_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff      <= req_data.row;
         col_ff      <= req_data.col;
         sample_ff   <= req_data.sample;
         in_store_ff <= in_store;
         r_ff        <= r_lo;
         c_ff        <= c_lo;
         c_lo_ff     <= c_lo;
         r_hi_ff     <= r_hi;
         c_hi_ff     <= c_hi;
         best_ff     <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
         if (uword.rd_scan) begin
            if (c_ff == c_hi_ff) begin
               c_ff <= c_lo_ff;
               r_ff <= r_ff + 7'd1;
            end else begin
               c_ff <= c_ff + 7'd1;
            end
         end
         if (scan_pend_ff) begin
            best_ff <= run_max;
         end
      end
      if (uword.rsp_en) begin
         rsp_data_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_pend_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         scan_pend_ff  <= uword.rd_scan;
         rsp_strobe_ff <= uword.rsp_en;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

[src/mf2d_checker.sv]
module mf2d_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input mf2d_pkg::req_type req_data,
   input logic              rsp_strobe,
   input mf2d_pkg::rsp_type rsp_data
);
   import mf2d_pkg::*;

   // a write beat is answered with a strobe, a zero result and ok set
   write_ack: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_data.kind |-> ##2
         (rsp_strobe && rsp_data.ok && rsp_data.result == '0))
      else $error("write beat not acknowledged on time");

   accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted beat");

   rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while the sequencer is still busy");

   single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two responses in consecutive cycles");

endmodule

bind max_filter_2d_core mf2d_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

[sim/tb_max_filter_2d_core.sv]
`timescale 1ns / 1ps

module tb_max_filter_2d_core;
   import mf2d_pkg::*;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;
   localparam int   STORE_ROWS  = 64;
   localparam int   STORE_COLS  = 64;
   localparam int   FILL_SIDE   = 24;
   localparam int   STALL_LIMIT = 20000;
   localparam int   MAX_REPORTS = 10;

   logic                  clock;
   logic                  reset    = 1'b1;
   logic                  start    = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  psel     = 1'b0;
   logic                  penable  = 1'b0;
   logic                  pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr    = '0;
   logic [CSR_DATA_W-1:0] pwdata   = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   max_filter_2d_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   // local image of the sample store and the CSRs
   logic signed [SAMPLE_W-1:0] pixel_copy [0:STORE_ROWS*STORE_COLS-1];
   bit               written [0:STORE_ROWS*STORE_COLS-1];
   logic [CNT_W-1:0] row_cnt  = ROW_COUNT_RESET;
   logic [CNT_W-1:0] col_cnt  = COL_COUNT_RESET;
   logic [CNT_W-1:0] win_size = WINDOW_SIZE_RESET;

   rsp_type pending_results [$];
   int      fail_count   = 0;
   int      stall_cycles = 0;

   typedef struct {
      bit                 is_cfg;
      reg_index_type      idx;
      logic [CNT_W-1:0]   val;
      req_type            item;
      bit                 typed;
      rsp_type            want;
   } script_row_type;

   script_row_type directed_script [$];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
   endfunction

   function automatic int clamp_count(input logic [CNT_W-1:0] c);
      return (c > STORE_ROWS) ? STORE_ROWS : int'(c);
   endfunction

   // windowed max with border clipping; updates the store image on writes
   function automatic rsp_type filter_step(input req_type it);
      rsp_type                    r;
      int                         rows, cols, radius, r0, r1, c0, c1, rr, cc;
      logic signed [SAMPLE_W-1:0] best;
      bit                         valid;
      rows = clamp_count(row_cnt);
      cols = clamp_count(col_cnt);
      if (it.kind == KIND_WRITE) begin
         pixel_copy[{it.row, it.col}] = it.sample;
         written[{it.row, it.col}]    = 1'b1;
         r.result = '0;
         r.ok     = 1'b1;
         return r;
      end
      best  = pixel_copy[{it.row, it.col}];
      valid = (win_size != 0) && win_size[0] && (win_size <= rows) && (win_size <= cols)
              && (it.row < rows) && (it.col < cols);
      if (valid) begin
         radius = int'(win_size) / 2;
         r0 = int'(it.row) - radius;
         r1 = int'(it.row) + radius;
         c0 = int'(it.col) - radius;
         c1 = int'(it.col) + radius;
         if (r0 < 0) r0 = 0;
         if (c0 < 0) c0 = 0;
         if (r1 > rows - 1) r1 = rows - 1;
         if (c1 > cols - 1) c1 = cols - 1;
         for (rr = r0; rr <= r1; rr++)
            for (cc = c0; cc <= c1; cc++)
               if (pixel_copy[rr*STORE_COLS + cc] > best) best = pixel_copy[rr*STORE_COLS + cc];
      end
      r.result = best;
      r.ok     = valid;
      return r;
   endfunction

   // true when every entry a query would read has been written
   function automatic bit reads_written(input req_type it);
      int rows, cols, radius, r0, r1, c0, c1, rr, cc;
      bit all_set;
      rows    = clamp_count(row_cnt);
      cols    = clamp_count(col_cnt);
      all_set = written[{it.row, it.col}];
      if (win_size[0] && (win_size <= rows) && (win_size <= cols)
          && (it.row < rows) && (it.col < cols)) begin
         radius = int'(win_size) / 2;
         r0 = int'(it.row) - radius;
         r1 = int'(it.row) + radius;
         c0 = int'(it.col) - radius;
         c1 = int'(it.col) + radius;
         if (r0 < 0) r0 = 0;
         if (c0 < 0) c0 = 0;
         if (r1 > rows - 1) r1 = rows - 1;
         if (c1 > cols - 1) c1 = cols - 1;
         for (rr = r0; rr <= r1; rr++)
            for (cc = c0; cc <= c1; cc++)
               if (!written[rr*STORE_COLS + cc]) all_set = 1'b0;
      end
      return all_set;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic int pick_index(input int lim, input int span);
      if (lim == 0 || $urandom_range(0, 4) == 0) return $urandom_range(0, span - 1);
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return lim - 1;
         default: return $urandom_range(0, lim - 1);
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CNT_W'($urandom_range(STORE_ROWS + 1, 127));
         2:       return CNT_W'(STORE_ROWS);
         default: return CNT_W'($urandom_range(1, FILL_SIDE));
      endcase
   endfunction

   function automatic void add_cfg(input reg_index_type idx, input int val);
      script_row_type s;
      s        = '{default: '0};
      s.is_cfg = 1'b1;
      s.idx    = idx;
      s.val    = CNT_W'(val);
      directed_script.push_back(s);
   endfunction

   function automatic void add_item(input logic kind, input int row, input int col,
                                    input int sample, input bit typed,
                                    input int want_result, input bit want_ok);
      script_row_type s;
      s             = '{default: '0};
      s.item.kind   = kind;
      s.item.row    = INDEX_W'(row);
      s.item.col    = INDEX_W'(col);
      s.item.sample = SAMPLE_W'(sample);
      s.typed       = typed;
      s.want.result = SAMPLE_W'(want_result);
      s.want.ok     = want_ok;
      directed_script.push_back(s);
   endfunction

   // leaves start high so the next beat can follow back to back
   task automatic send_beat(input req_type it, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      start    <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      predicted = filter_step(it);
      pending_results.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_results.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write, then read back over a back-to-back transfer
   task automatic csr_write(input reg_index_type idx, input logic [CNT_W-1:0] val);
      logic [CSR_DATA_W-1:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= CSR_DATA_W'(val);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_ROW_COUNT:   row_cnt  = val;
         REG_COL_COUNT:   col_cnt  = val;
         REG_WINDOW_SIZE: win_size = val;
         default:         ;
      endcase
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      if (readback !== CSR_DATA_W'(val))
         note_failure($sformatf("csr %0d readback: expected %0d, got %0d", idx, val, readback));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("result with nothing pending: %0d ok %0b",
                                   rsp_data.result, rsp_data.ok));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.result !== want.result)
               note_failure($sformatf("result: expected %0d, got %0d",
                                      want.result, rsp_data.result));
            if (rsp_data.ok !== want.ok)
               note_failure($sformatf("ok: expected %0b, got %0b", want.ok, rsp_data.ok));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable && pready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      req_type          it;
      script_row_type   srow;
      int               phase, n_items, k, idle_pct, min_eff, span, lim_r, lim_c;
      logic [CNT_W-1:0] cfg_rows, cfg_cols, cfg_win;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // queries may only touch written entries: fill a corner block first,
      // random queries that would reach past written entries become writes
      for (k = 0; k < FILL_SIDE*FILL_SIDE; k++) begin
         it.kind   = KIND_WRITE;
         it.row    = INDEX_W'(k / FILL_SIDE);
         it.col    = INDEX_W'(k % FILL_SIDE);
         it.sample = pick_sample();
         send_beat(it, 1'b0, '0);
      end

      // directed: corners with extreme samples, then window and matrix corner cases
      add_cfg(REG_ROW_COUNT, FILL_SIDE);                  // matrix matches the filled block
      add_cfg(REG_COL_COUNT, FILL_SIDE);
      add_item(KIND_WRITE, 0, 0, 32767, 1, 0, 1);
      add_item(KIND_WRITE, FILL_SIDE-1, FILL_SIDE-1, -32768, 1, 0, 1);
      add_item(KIND_WRITE, 0, FILL_SIDE-1, -1, 1, 0, 1);
      add_item(KIND_WRITE, FILL_SIDE-1, 0, 0, 1, 0, 1);
      add_item(KIND_QUERY, 0, 0, 16'hFFFF, 0, 0, 0);
      add_item(KIND_QUERY, FILL_SIDE-1, FILL_SIDE-1, 0, 0, 0, 0);
      add_item(KIND_QUERY, 11, 11, 16'h8000, 0, 0, 0);
      add_cfg(REG_WINDOW_SIZE, 4);                        // even window
      add_item(KIND_QUERY, 0, 0, 0, 1, 32767, 0);
      add_item(KIND_QUERY, FILL_SIDE-1, FILL_SIDE-1, 0, 1, -32768, 0);
      add_cfg(REG_WINDOW_SIZE, 0);
      add_item(KIND_QUERY, 0, FILL_SIDE-1, 0, 1, -1, 0);
      add_cfg(REG_ROW_COUNT, 127);                        // counts clamp to the store
      add_cfg(REG_COL_COUNT, 127);
      add_cfg(REG_WINDOW_SIZE, 65);                       // too wide after clamping
      add_item(KIND_QUERY, FILL_SIDE-1, 0, 0, 1, 0, 0);
      add_cfg(REG_WINDOW_SIZE, 1);
      add_item(KIND_QUERY, 0, 0, 0, 1, 32767, 1);
      add_cfg(REG_WINDOW_SIZE, 3);
      add_item(KIND_QUERY, 5, 5, 0, 0, 0, 0);
      add_cfg(REG_ROW_COUNT, 0);
      add_item(KIND_QUERY, 0, 0, 0, 1, 32767, 0);
      add_cfg(REG_ROW_COUNT, 1);
      add_cfg(REG_COL_COUNT, 1);
      add_cfg(REG_WINDOW_SIZE, 1);
      add_item(KIND_QUERY, 0, 0, 0, 1, 32767, 1);
      add_item(KIND_QUERY, 0, FILL_SIDE-1, 0, 1, -1, 0);  // outside active matrix
      add_cfg(REG_COL_COUNT, 0);
      add_item(KIND_QUERY, FILL_SIDE-1, FILL_SIDE-1, 0, 1, -32768, 0);
      add_cfg(REG_ROW_COUNT, FILL_SIDE);
      add_cfg(REG_COL_COUNT, FILL_SIDE);
      add_cfg(REG_WINDOW_SIZE, 3);
      add_item(KIND_WRITE, 5, 5, 16'h5555, 1, 0, 1);
      add_item(KIND_WRITE, 5, 6, 16'hAAAA, 1, 0, 1);
      add_item(KIND_QUERY, 5, 5, 0, 0, 0, 0);
      add_item(KIND_QUERY, 4, 6, 0, 0, 0, 0);
      add_cfg(REG_WINDOW_SIZE, 23);                       // widest odd window in the block
      add_item(KIND_QUERY, FILL_SIDE-1, 0, 0, 0, 0, 0);
      add_item(KIND_QUERY, 11, 11, 0, 0, 0, 0);

      foreach (directed_script[i]) begin
         srow = directed_script[i];
         if (srow.is_cfg) begin
            drain();
            csr_write(srow.idx, srow.val);
         end else begin
            send_beat(srow.item, srow.typed, srow.want);
         end
      end

      for (phase = 0; phase < 12; phase++) begin
         idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 63 : 32;
         case (phase)
            0: begin
               cfg_rows = 7'd64; cfg_cols = 7'd64; cfg_win = 7'd3;
            end
            4: begin
               cfg_rows = CNT_W'(FILL_SIDE); cfg_cols = CNT_W'(FILL_SIDE); cfg_win = 7'd23;
            end
            8: begin
               cfg_rows = CNT_W'(FILL_SIDE); cfg_cols = CNT_W'(FILL_SIDE); cfg_win = 7'd15;
            end
            default: begin
               cfg_rows = pick_count();
               cfg_cols = pick_count();
               min_eff  = (clamp_count(cfg_rows) < clamp_count(cfg_cols)) ?
                          clamp_count(cfg_rows) : clamp_count(cfg_cols);
               case ($urandom_range(0, 9))
                  0:       cfg_win = CNT_W'(2 * $urandom_range(1, 4));
                  1:       cfg_win = '0;
                  2:       cfg_win = CNT_W'($urandom_range(min_eff + 1, 127));
                  default: cfg_win = CNT_W'(2 * $urandom_range(0, 4) + 1);
               endcase
            end
         endcase
         drain();
         csr_write(REG_ROW_COUNT, cfg_rows);
         csr_write(REG_COL_COUNT, cfg_cols);
         csr_write(REG_WINDOW_SIZE, cfg_win);

         n_items = 90;
         for (k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 59) == 0)
               drain();
            else if ($urandom_range(0, 99) < idle_pct)
               idle_gap($urandom_range(1, 6));
            it.kind   = ($urandom_range(0, 9) < 4) ? KIND_WRITE : KIND_QUERY;
            span      = (it.kind == KIND_QUERY) ? FILL_SIDE : STORE_ROWS;
            lim_r     = (clamp_count(row_cnt) < span) ? clamp_count(row_cnt) : span;
            lim_c     = (clamp_count(col_cnt) < span) ? clamp_count(col_cnt) : span;
            it.row    = INDEX_W'(pick_index(lim_r, span));
            it.col    = INDEX_W'(pick_index(lim_c, span));
            it.sample = pick_sample();
            if (it.kind == KIND_QUERY && !reads_written(it))
               it.kind = KIND_WRITE;
            send_beat(it, 1'b0, '0);
         end
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[files.f]
src/mf2d_pkg.sv
src/mf2d_csr.sv
src/mf2d_sequencer.sv
src/mf2d_datapath.sv
src/max_filter_2d_core.sv
src/mf2d_checker.sv
sim/tb_max_filter_2d_core.sv
